@@ hdl/i8pe_pkg.sv @@
// ----------------------------------------------------------------------------
// i8pe_pkg
// Shared widths, constants and types for the int8 convolution PE.
// ----------------------------------------------------------------------------
`default_nettype none

package i8pe_pkg;

	localparam int LANES_DEFAULT = 16;
	localparam int BYTE_W        = 8;
	localparam int PROD_W        = 16;
	localparam int GROUP_SIZE    = 4;
	localparam int ACC_W         = 32;
	localparam int SHIFT_W       = 5;
	localparam int OUT_W         = 8;
	localparam int DATA_W        = 256;
	localparam int WORD_W        = 64;

	localparam logic [SHIFT_W-1:0] SHIFT_RESET = SHIFT_W'(8);

	localparam int OUT_MAX = 127;
	localparam int OUT_MIN = -128;

	// per-stage control word
	typedef struct packed {
		logic valid;
		logic last;
	} ctl_t;

endpackage

`default_nettype wire

@@ hdl/i8pe_lane.sv @@
// ----------------------------------------------------------------------------
// i8pe_lane
// One multiplier lane: signed 8x8 product, product forced to zero on padding.
// ----------------------------------------------------------------------------
`default_nettype none

module i8pe_lane (
	input  wire logic                             clk,
	input  wire logic                             load,
	input  wire logic                             pad,
	input  wire logic [i8pe_pkg::BYTE_W-1:0]      feat,
	input  wire logic [i8pe_pkg::BYTE_W-1:0]      wgt,
	output logic      [i8pe_pkg::PROD_W-1:0]      prod_s1
);

	logic signed [i8pe_pkg::PROD_W-1:0] prod;

	always_comb begin
		prod = $signed(feat) * $signed(wgt);
		if (pad) begin
			prod = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			prod_s1 <= prod;
		end
	end

endmodule

`default_nettype wire

@@ hdl/i8pe_tree.sv @@
// ----------------------------------------------------------------------------
// i8pe_tree
// Two-level registered adder tree merging the lane products into one dot product.
// ----------------------------------------------------------------------------
`default_nettype none

module i8pe_tree #(
	parameter int LANES = i8pe_pkg::LANES_DEFAULT
) (
	input  wire logic                                    clk,
	input  wire logic                                    arst_n,
	input  wire i8pe_pkg::ctl_t                          ctl_s1,
	input  wire logic [LANES-1:0][i8pe_pkg::PROD_W-1:0]  prod_s1,
	output logic                                         in_ready,
	input  wire logic                                    dn_ready,
	output i8pe_pkg::ctl_t                               ctl_s3,
	output logic [i8pe_pkg::PROD_W+$clog2(i8pe_pkg::GROUP_SIZE)
		+$clog2((LANES+i8pe_pkg::GROUP_SIZE-1)/i8pe_pkg::GROUP_SIZE)-1:0] dot_s3
);

	localparam int GS     = i8pe_pkg::GROUP_SIZE;
	localparam int GROUPS = (LANES + GS - 1) / GS;
	localparam int GRP_W  = i8pe_pkg::PROD_W + $clog2(GS);
	localparam int SUM_W  = GRP_W + $clog2(GROUPS);

	i8pe_pkg::ctl_t               ctl_s2;
	logic [GROUPS-1:0][GRP_W-1:0] grp_sum;
	logic [GROUPS-1:0][GRP_W-1:0] grp_s2;
	logic signed [SUM_W-1:0]      dot_sum;
	logic                         ready_s2;
	logic                         ready_s3;

	assign ready_s3 = !ctl_s3.valid || dn_ready;
	assign ready_s2 = !ctl_s2.valid || ready_s3;
	assign in_ready = ready_s2;

	for (genvar g = 0; g < GROUPS; g++) begin : g_grp
		always_comb begin
			logic signed [GRP_W-1:0] acc;
			acc = '0;
			for (int j = 0; j < GS; j++) begin
				if (g * GS + j < LANES) begin
					acc = acc + GRP_W'($signed(prod_s1[g * GS + j]));
				end
			end
			grp_sum[g] = acc;
		end
	end

	always_comb begin
		dot_sum = '0;
		for (int g = 0; g < GROUPS; g++) begin
			dot_sum = dot_sum + SUM_W'($signed(grp_s2[g]));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
			ctl_s3 <= '0;
		end else begin
			if (ready_s2) begin
				ctl_s2 <= ctl_s1;
			end
			if (ready_s3) begin
				ctl_s3 <= ctl_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && ctl_s1.valid) begin
			grp_s2 <= grp_sum;
		end
		if (ready_s3 && ctl_s2.valid) begin
			dot_s3 <= dot_sum;
		end
	end

endmodule

`default_nettype wire

@@ hdl/i8pe_requant.sv @@
// ----------------------------------------------------------------------------
// i8pe_requant
// Wrapping 32-bit accumulator, then arithmetic shift and int8 saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module i8pe_requant #(
	parameter int SUM_W = 20
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire i8pe_pkg::ctl_t                ctl_in,
	input  wire logic [SUM_W-1:0]              dot_in,
	output logic                               in_ready,
	input  wire logic [i8pe_pkg::SHIFT_W-1:0]  shift_amt,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [i8pe_pkg::OUT_W-1:0]         out_data
);

	localparam int ACC_W = i8pe_pkg::ACC_W;

	logic [ACC_W-1:0]        acc_q;
	logic [ACC_W-1:0]        acc_next;
	logic [ACC_W-1:0]        sum_s4;
	logic                    valid_s4;
	logic                    ready_out;
	logic                    take;
	logic signed [ACC_W-1:0] shifted;
	logic [i8pe_pkg::OUT_W-1:0] sat;

	assign ready_out = !out_valid || out_ready;
	assign in_ready  = !valid_s4 || ready_out;
	assign take      = ctl_in.valid && in_ready;
	assign acc_next  = acc_q + ACC_W'($signed(dot_in));

	always_comb begin
		shifted = $signed(sum_s4) >>> shift_amt;
		if (shifted > i8pe_pkg::OUT_MAX) begin
			sat = i8pe_pkg::OUT_W'(i8pe_pkg::OUT_MAX);
		end else if (shifted < i8pe_pkg::OUT_MIN) begin
			sat = i8pe_pkg::OUT_W'(i8pe_pkg::OUT_MIN);
		end else begin
			sat = shifted[i8pe_pkg::OUT_W-1:0];
		end
	end

	// only last beats occupy the result stage; others just fold into the sum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q     <= '0;
			valid_s4  <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (take) begin
				acc_q <= ctl_in.last ? '0 : acc_next;
			end
			if (in_ready) begin
				valid_s4 <= take && ctl_in.last;
			end
			if (ready_out) begin
				out_valid <= valid_s4;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && ctl_in.last) begin
			sum_s4 <= acc_next;
		end
		if (ready_out && valid_s4) begin
			out_data <= sat;
		end
	end

	a_clear_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		take && ctl_in.last |=> acc_q == '0)
		else $error("accumulator not cleared after last beat");

	a_accumulate: assert property (@(posedge clk) disable iff (!arst_n)
		take && !ctl_in.last |=> acc_q == $past(acc_next))
		else $error("accumulator update wrong");

	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s4 && !ready_out |=> valid_s4 && $stable(sum_s4))
		else $error("pending result lost while output stalled");

endmodule

`default_nettype wire

@@ hdl/int8_conv_pe_accumulate_requantize.sv @@
// Stages, each a pipeline slot with its own valid: lanes, groups, dot, sum, output.
// Throughput: one input beat per cycle while no output stall backs up into the input.
// Only last beats produce an output beat; a stalled output backs up through the pipeline.
// Reset: accumulator cleared, result_shift set to 8, all stages emptied.
// ----------------------------------------------------------------------------
// int8_conv_pe_accumulate_requantize
// Convolution PE: parallel int8 multiplier lanes, adder tree, accumulator and
// requantiser with an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module int8_conv_pe_accumulate_requantize #(
	parameter int LANES = i8pe_pkg::LANES_DEFAULT
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_wr_en,
	input  wire logic [i8pe_pkg::SHIFT_W-1:0]   cfg_wr_data,   // result_shift
	input  wire logic                           s_axis_tvalid,
	output logic                                s_axis_tready,
	// feature_low, feature_high, weight_low, weight_high
	input  wire logic [i8pe_pkg::DATA_W-1:0]    s_axis_tdata,
	input  wire logic                           s_axis_tuser,  // pad_zero
	input  wire logic                           s_axis_tlast,  // last_chunk
	output logic                                m_axis_tvalid,
	input  wire logic                           m_axis_tready,
	output logic [i8pe_pkg::OUT_W-1:0]          m_axis_tdata   // output_value
);

	localparam int GS     = i8pe_pkg::GROUP_SIZE;
	localparam int GROUPS = (LANES + GS - 1) / GS;
	localparam int SUM_W  = i8pe_pkg::PROD_W + $clog2(GS) + $clog2(GROUPS);
	localparam int BW     = i8pe_pkg::BYTE_W;
	localparam int WOFF   = 2 * i8pe_pkg::WORD_W;

	logic [i8pe_pkg::SHIFT_W-1:0]           shift_q;
	i8pe_pkg::ctl_t                         ctl_s1;
	i8pe_pkg::ctl_t                         ctl_s3;
	logic [LANES-1:0][i8pe_pkg::PROD_W-1:0] prod_s1;
	logic [SUM_W-1:0]                       dot_s3;
	logic                                   tree_ready;
	logic                                   rq_ready;
	logic                                   load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q <= i8pe_pkg::SHIFT_RESET;
		end else if (cfg_wr_en) begin
			shift_q <= cfg_wr_data;
		end
	end

	assign s_axis_tready = !ctl_s1.valid || tree_ready;
	assign load          = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (s_axis_tready) begin
			ctl_s1.valid <= s_axis_tvalid;
			ctl_s1.last  <= s_axis_tlast;
		end
	end

	// feature bytes sit contiguously in the low 128 bits, weights above them
	for (genvar i = 0; i < LANES; i++) begin : g_lane
		i8pe_lane u_lane (
			.clk     (clk),
			.load    (load),
			.pad     (s_axis_tuser),
			.feat    (s_axis_tdata[i*BW +: BW]),
			.wgt     (s_axis_tdata[WOFF + i*BW +: BW]),
			.prod_s1 (prod_s1[i])
		);
	end

	i8pe_tree #(
		.LANES (LANES)
	) u_tree (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl_s1   (ctl_s1),
		.prod_s1  (prod_s1),
		.in_ready (tree_ready),
		.dn_ready (rq_ready),
		.ctl_s3   (ctl_s3),
		.dot_s3   (dot_s3)
	);

	i8pe_requant #(
		.SUM_W (SUM_W)
	) u_requant (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl_in    (ctl_s3),
		.dot_in    (dot_s3),
		.in_ready  (rq_ready),
		.shift_amt (shift_q),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata)
	);

endmodule

`default_nettype wire
